### rtl/assert_macros.svh
// Assertion macros used by the mailbox splitter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, ck, rn, prop)
`define ASSERT_NEVER(lbl, ck, rn, cond)
`endif
`endif

### rtl/mbox_pkg.sv
// Types, symbol codes and the microcode ROM of the mailbox splitter
package mbox_pkg;

  localparam int NumStates = 44;
  localparam logic [5:0] StartState = 6'd31;

  localparam logic [8:0] SymNl    = 9'h00A;
  localparam logic [8:0] SymSp    = 9'h020;
  localparam logic [8:0] SymGt    = 9'h03E;
  localparam logic [8:0] SymF     = 9'h046;
  localparam logic [8:0] SymM     = 9'h06D;
  localparam logic [8:0] SymO     = 9'h06F;
  localparam logic [8:0] SymR     = 9'h072;
  localparam logic [8:0] SymEof   = 9'h100;
  localparam logic [8:0] SymWild  = 9'h101;
  localparam logic [8:0] SymSkip  = 9'h102;
  localparam logic [8:0] SymHeld  = 9'h103;
  localparam logic [8:0] SymMsg   = 9'h104;
  localparam logic [8:0] SymEmpty = 9'h105;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_MSG   = 2'd1,
    KIND_EOF   = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef struct packed {
    logic [8:0] m;
    logic [8:0] e;
    logic [5:0] n;
  } urow_t;

  typedef urow_t [0:4] uword_t;

  typedef struct packed {
    logic       emit_v;
    logic [8:0] emit_sym;
    logic       cap_v;
    logic [8:0] cap_sym;
    logic [5:0] next;
    logic       done;
  } step_res_t;

  localparam urow_t Pad = '0;

  function automatic urow_t rw(input logic [8:0] m, input logic [8:0] e,
                               input logic [5:0] n);
    urow_t r;
    r.m = m;
    r.e = e;
    r.n = n;
    return r;
  endfunction

  function automatic uword_t wd(input urow_t r0, input urow_t r1, input urow_t r2,
                                input urow_t r3, input urow_t r4);
    uword_t w;
    w[0] = r0;
    w[1] = r1;
    w[2] = r2;
    w[3] = r3;
    w[4] = r4;
    return w;
  endfunction

  function automatic uword_t sk(input logic [8:0] e, input logic [5:0] n);
    return wd(rw(SymSkip, e, n), Pad, Pad, Pad, Pad);
  endfunction

  function automatic uword_t srch(input logic [8:0] m, input logic [5:0] n,
                                  input logic [5:0] miss);
    return wd(rw(m, SymSkip, n), rw(SymEof, SymEmpty, 6'd31),
              rw(SymWild, SymSkip, miss), Pad, Pad);
  endfunction

  function automatic uword_t mbx_rom(input logic [5:0] st);
    uword_t w;
    unique case (st)
      6'd0:  w = wd(rw(SymNl, SymSkip, 6'd1), rw(SymEof, SymEof, 6'd31),
                    rw(SymWild, SymWild, 6'd0), Pad, Pad);
      6'd1:  w = wd(rw(SymF, SymSkip, 6'd3), rw(SymEof, SymEof, 6'd31),
                    rw(SymGt, SymNl, 6'd22), rw(SymNl, SymNl, 6'd1),
                    rw(SymWild, SymNl, 6'd2));
      6'd2:  w = sk(SymWild, 6'd38);
      6'd3:  w = wd(rw(SymR, SymSkip, 6'd6), rw(SymEof, SymEof, 6'd31),
                    rw(SymWild, SymNl, 6'd4), Pad, Pad);
      6'd4:  w = sk(SymF, 6'd5);
      6'd5:  w = sk(SymWild, 6'd38);
      6'd6:  w = wd(rw(SymO, SymSkip, 6'd10), rw(SymEof, SymEof, 6'd31),
                    rw(SymWild, SymNl, 6'd7), Pad, Pad);
      6'd7:  w = sk(SymF, 6'd8);
      6'd8:  w = sk(SymR, 6'd9);
      6'd9:  w = sk(SymWild, 6'd38);
      6'd10: w = wd(rw(SymM, SymSkip, 6'd15), rw(SymEof, SymEof, 6'd31),
                    rw(SymWild, SymNl, 6'd11), Pad, Pad);
      6'd11: w = sk(SymF, 6'd12);
      6'd12: w = sk(SymR, 6'd13);
      6'd13: w = sk(SymO, 6'd14);
      6'd14: w = sk(SymWild, 6'd38);
      6'd15: w = wd(rw(SymSp, SymSkip, 6'd21), rw(SymEof, SymEof, 6'd31),
                    rw(SymWild, SymNl, 6'd16), Pad, Pad);
      6'd16: w = sk(SymF, 6'd17);
      6'd17: w = sk(SymR, 6'd18);
      6'd18: w = sk(SymO, 6'd19);
      6'd19: w = sk(SymM, 6'd20);
      6'd20: w = sk(SymWild, 6'd38);
      6'd21: w = wd(rw(SymNl, SymMsg, 6'd37), rw(SymEof, SymEof, 6'd31),
                    rw(SymWild, SymSkip, 6'd21), Pad, Pad);
      6'd22: w = wd(rw(SymGt, SymGt, 6'd22), rw(SymF, SymSkip, 6'd23),
                    rw(SymWild, SymGt, 6'd2), Pad, Pad);
      6'd23: w = wd(rw(SymR, SymSkip, 6'd24), rw(SymWild, SymGt, 6'd4), Pad, Pad, Pad);
      6'd24: w = wd(rw(SymO, SymSkip, 6'd25), rw(SymWild, SymGt, 6'd7), Pad, Pad, Pad);
      6'd25: w = wd(rw(SymM, SymSkip, 6'd26), rw(SymWild, SymGt, 6'd11), Pad, Pad, Pad);
      6'd26: w = wd(rw(SymSp, SymF, 6'd27), rw(SymWild, SymGt, 6'd16), Pad, Pad, Pad);
      6'd27: w = sk(SymR, 6'd28);
      6'd28: w = sk(SymO, 6'd29);
      6'd29: w = sk(SymM, 6'd30);
      6'd30: w = sk(SymSp, 6'd0);
      6'd31: w = srch(SymF, 6'd32, 6'd31);
      6'd32: w = srch(SymR, 6'd33, 6'd31);
      6'd33: w = srch(SymO, 6'd34, 6'd31);
      6'd34: w = srch(SymM, 6'd35, 6'd31);
      6'd35: w = srch(SymSp, 6'd36, 6'd31);
      6'd36: w = srch(SymNl, 6'd37, 6'd36);
      6'd37: w = wd(rw(SymF, SymSkip, 6'd40), rw(SymEof, SymEof, 6'd31),
                    rw(SymGt, SymSkip, 6'd22), rw(SymWild, SymSkip, 6'd2),
                    rw(SymWild, SymSkip, 6'd2));
      6'd38: w = wd(rw(SymHeld, SymSkip, 6'd0), rw(SymNl, SymSkip, 6'd39),
                    rw(SymWild, SymSkip, 6'd0), Pad, Pad);
      6'd39: w = wd(rw(SymF, SymSkip, 6'd3), rw(SymEof, SymEof, 6'd31),
                    rw(SymGt, SymSkip, 6'd22), rw(SymNl, SymSkip, 6'd1),
                    rw(SymWild, SymSkip, 6'd2));
      6'd40: w = wd(rw(SymR, SymSkip, 6'd41), rw(SymEof, SymEof, 6'd31),
                    rw(SymWild, SymSkip, 6'd4), Pad, Pad);
      6'd41: w = wd(rw(SymO, SymSkip, 6'd42), rw(SymEof, SymEof, 6'd31),
                    rw(SymWild, SymSkip, 6'd7), Pad, Pad);
      6'd42: w = wd(rw(SymM, SymSkip, 6'd43), rw(SymEof, SymEof, 6'd31),
                    rw(SymWild, SymSkip, 6'd11), Pad, Pad);
      6'd43: w = wd(rw(SymSp, SymSkip, 6'd21), rw(SymEof, SymEof, 6'd31),
                    rw(SymWild, SymSkip, 6'd16), Pad, Pad);
      default: w = srch(SymF, 6'd32, 6'd31);
    endcase
    return w;
  endfunction

  function automatic kind_t sym_kind(input logic [8:0] sym);
    kind_t k;
    if (!sym[8]) begin
      k = KIND_BYTE;
    end else if (sym == SymMsg) begin
      k = KIND_MSG;
    end else if (sym == SymEmpty) begin
      k = KIND_EMPTY;
    end else begin
      k = KIND_EOF;
    end
    return k;
  endfunction

  function automatic logic [7:0] sym_byte(input logic [8:0] sym);
    return sym[8] ? 8'h00 : sym[7:0];
  endfunction

endpackage

### rtl/mbox_if.sv
// Valid/ready channel interfaces for mailbox bytes in and symbols out
interface mbox_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_file;

  modport source (output valid, output byte_value, output end_of_file, input ready);
  modport sink   (input valid, input byte_value, input end_of_file, output ready);
endinterface

interface mbox_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol_kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output symbol_kind, output out_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input symbol_kind, input out_byte, input last_of_run,
                  output ready);
endinterface

### rtl/mbox_ustep.sv
// One microcode step: ROM fetch, row match, emit and branch decode
module mbox_ustep (
  input  logic [5:0]           state,
  input  logic [8:0]           in_sym,
  input  logic [8:0]           held,
  output mbox_pkg::step_res_t  res
);
  import mbox_pkg::*;

  uword_t     word;
  uword_t     nword;
  logic       skip_mode;
  logic       hold_mode;
  logic [8:0] sym;
  logic [2:0] sel;
  logic       found;
  logic       cap;
  logic [8:0] held_new;
  logic [8:0] emit;
  logic [5:0] nxt;

  always_comb begin
    word      = mbx_rom(state);
    skip_mode = (word[0].m == SymSkip);
    hold_mode = (word[0].m == SymHeld);
    sym       = hold_mode ? held : in_sym;
    sel       = hold_mode ? 3'd1 : 3'd0;
    found     = 1'b0;
    cap       = 1'b0;
    for (int k = 0; k < 5; k++) begin
      if (!skip_mode && !found && (k > 0 || !hold_mode)) begin
        if (word[k].m == SymWild) begin
          found = 1'b1;
          cap   = 1'b1;
          sel   = 3'(k);
        end else if (word[k].m == sym) begin
          found = 1'b1;
          sel   = 3'(k);
        end
      end
    end
    held_new = cap ? sym : held;
    emit     = word[sel].e;
    if (emit == SymWild) begin
      emit = held_new;
    end
    nxt = word[sel].n;
    if (nxt >= 6'(NumStates)) begin
      nxt = StartState;
    end
    nword        = mbx_rom(nxt);
    res.emit_v   = (emit != SymSkip);
    res.emit_sym = emit;
    res.cap_v    = cap;
    res.cap_sym  = sym;
    res.next     = nxt;
    res.done     = (nword[0].m != SymSkip) && (nword[0].m != SymHeld);
  end

endmodule

### rtl/mbox_message_splitter.sv
// Top level of the mailbox splitter: request intake, sequencer and result register
//
// channel  dir  payload
// in_ch    in   byte_value[7:0], end_of_file
// out_ch   out  symbol_kind[1:0], out_byte[7:0], last_of_run
//
// One request is taken, then one microcode step runs per cycle until a reading state,
// but only while the result register is free; no new request is taken meanwhile.
// When the final step emits while an earlier symbol is still pending, a flush step follows.
// Symbols stall in the result register while out_ch.ready is low; stepping waits for it.
// Reset sets the sequencer to the first-From search state with nothing in flight.
`include "assert_macros.svh"

module mbox_message_splitter (
  input  logic       clk,
  input  logic       rst_n,
  mbox_in_if.sink    in_ch,
  mbox_out_if.source out_ch
);
  import mbox_pkg::*;

  logic       busy_r, busy_nxt;
  logic       flush_r, flush_nxt;
  logic [8:0] sym_r, sym_nxt;
  logic [5:0] state_r, state_nxt;
  logic [8:0] held_r, held_nxt;
  logic       pend_v_r, pend_v_nxt;
  logic [8:0] pend_sym_r, pend_sym_nxt;
  logic       out_v_r, out_v_nxt;
  kind_t      out_kind_r, out_kind_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic       in_acc;
  logic       out_free;
  logic       step_go;
  logic       flush_go;
  logic       push;
  logic [8:0] push_sym;
  logic       push_last;
  step_res_t  res;

  mbox_ustep u_step (
    .state  (state_r),
    .in_sym (sym_r),
    .held   (held_r),
    .res    (res)
  );

  assign in_ch.ready        = !busy_r;
  assign in_acc             = in_ch.valid && !busy_r;
  assign out_free           = !out_v_r || out_ch.ready;
  assign step_go            = busy_r && !flush_r && out_free;
  assign flush_go           = busy_r && flush_r && out_free;
  assign out_ch.valid       = out_v_r;
  assign out_ch.symbol_kind = out_kind_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  always_comb begin
    busy_nxt     = busy_r;
    flush_nxt    = flush_r;
    sym_nxt      = sym_r;
    state_nxt    = state_r;
    held_nxt     = held_r;
    pend_v_nxt   = pend_v_r;
    pend_sym_nxt = pend_sym_r;
    out_v_nxt    = out_v_r;
    out_kind_nxt = out_kind_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    push         = 1'b0;
    push_sym     = pend_sym_r;
    push_last    = 1'b0;

    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    if (in_acc) begin
      busy_nxt = 1'b1;
      sym_nxt  = in_ch.end_of_file ? SymEof : {1'b0, in_ch.byte_value};
    end

    if (step_go) begin
      state_nxt = res.next;
      if (res.cap_v) begin
        held_nxt = res.cap_sym;
      end
      if (res.emit_v) begin
        if (pend_v_r) begin
          push         = 1'b1;
          pend_sym_nxt = res.emit_sym;
          if (res.done) begin
            flush_nxt = 1'b1;
          end
        end else if (res.done) begin
          push      = 1'b1;
          push_sym  = res.emit_sym;
          push_last = 1'b1;
          busy_nxt  = 1'b0;
        end else begin
          pend_v_nxt   = 1'b1;
          pend_sym_nxt = res.emit_sym;
        end
      end else if (res.done) begin
        busy_nxt = 1'b0;
        if (pend_v_r) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
    end else if (flush_go) begin
      push       = 1'b1;
      push_last  = 1'b1;
      pend_v_nxt = 1'b0;
      flush_nxt  = 1'b0;
      busy_nxt   = 1'b0;
    end

    if (push) begin
      out_v_nxt    = 1'b1;
      out_kind_nxt = sym_kind(push_sym);
      out_byte_nxt = sym_byte(push_sym);
      out_last_nxt = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      flush_r  <= 1'b0;
      state_r  <= StartState;
      held_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      flush_r  <= flush_nxt;
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    pend_sym_r <= pend_sym_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  `ASSERT_NEVER(a_pend_while_idle, clk, rst_n, !busy_r && pend_v_r)
  `ASSERT_NEVER(a_flush_without_pend, clk, rst_n, flush_r && !pend_v_r)
  `ASSERT_CLK(a_done_releases, clk, rst_n, (step_go && res.done && !res.emit_v) |=> !busy_r)

endmodule

### verif/testbench.sv
// Self-checking testbench for the mailbox splitter: mailbox streams in, symbols checked
module testbench;
  import mbox_pkg::*;

  localparam int CycleLimit   = 300000;
  localparam int RandomCount  = 320;
  localparam int IdlePercent  = 21;
  localparam int HoldCycles   = 80;
  localparam int DrainCycles  = 20;
  localparam int MaxReports   = 30;

  typedef struct {
    logic [7:0] value;
    logic       eof;
  } mbox_request_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } mbox_symbol_t;

  class symbol_scoreboard;
    logic [8:0]   rule_match [NumStates][5];
    logic [8:0]   rule_emit  [NumStates][5];
    logic [5:0]   rule_next  [NumStates][5];
    logic [5:0]   parse_state;
    logic [8:0]   captured;
    mbox_symbol_t expected_symbols [$];
    int           errors;
    int           kind_count [4];

    function void rule(int st, int k, logic [8:0] m, logic [8:0] e, logic [5:0] n);
      rule_match[st][k] = m;
      rule_emit[st][k]  = e;
      rule_next[st][k]  = n;
    endfunction

    function void chain(int st, logic [8:0] e, logic [5:0] n);
      rule(st, 0, SymSkip, e, n);
    endfunction

    function void reader(int st, logic [8:0] m, logic [8:0] e, logic [5:0] n,
                         logic [8:0] we, logic [5:0] wn);
      rule(st, 0, m, e, n);
      rule(st, 1, SymEof, SymEof, StartState);
      rule(st, 2, SymWild, we, wn);
    endfunction

    function void hunt(int st, logic [8:0] m, logic [5:0] n, logic [5:0] miss);
      rule(st, 0, m, SymSkip, n);
      rule(st, 1, SymEof, SymEmpty, StartState);
      rule(st, 2, SymWild, SymSkip, miss);
    endfunction

    function void escape(int st, logic [8:0] m, logic [8:0] e, logic [5:0] n,
                         logic [5:0] wn);
      rule(st, 0, m, e, n);
      rule(st, 1, SymWild, SymGt, wn);
    endfunction

    function new();
      for (int s = 0; s < NumStates; s++) begin
        for (int k = 0; k < 5; k++) begin
          rule(s, k, '0, '0, '0);
        end
      end
      reader(0, SymNl, SymSkip, 1, SymWild, 0);
      rule(1, 0, SymF, SymSkip, 3);   rule(1, 1, SymEof, SymEof, StartState);
      rule(1, 2, SymGt, SymNl, 22);   rule(1, 3, SymNl, SymNl, 1);
      rule(1, 4, SymWild, SymNl, 2);
      chain(2, SymWild, 38);
      reader(3, SymR, SymSkip, 6, SymNl, 4);
      chain(4, SymF, 5);   chain(5, SymWild, 38);
      reader(6, SymO, SymSkip, 10, SymNl, 7);
      chain(7, SymF, 8);   chain(8, SymR, 9);   chain(9, SymWild, 38);
      reader(10, SymM, SymSkip, 15, SymNl, 11);
      chain(11, SymF, 12); chain(12, SymR, 13); chain(13, SymO, 14);
      chain(14, SymWild, 38);
      reader(15, SymSp, SymSkip, 21, SymNl, 16);
      chain(16, SymF, 17); chain(17, SymR, 18); chain(18, SymO, 19);
      chain(19, SymM, 20); chain(20, SymWild, 38);
      reader(21, SymNl, SymMsg, 37, SymSkip, 21);
      rule(22, 0, SymGt, SymGt, 22);  rule(22, 1, SymF, SymSkip, 23);
      rule(22, 2, SymWild, SymGt, 2);
      escape(23, SymR, SymSkip, 24, 4);
      escape(24, SymO, SymSkip, 25, 7);
      escape(25, SymM, SymSkip, 26, 11);
      escape(26, SymSp, SymF, 27, 16);
      chain(27, SymR, 28); chain(28, SymO, 29); chain(29, SymM, 30);
      chain(30, SymSp, 0);
      hunt(31, SymF, 32, 31);  hunt(32, SymR, 33, 31);  hunt(33, SymO, 34, 31);
      hunt(34, SymM, 35, 31);  hunt(35, SymSp, 36, 31); hunt(36, SymNl, 37, 36);
      rule(37, 0, SymF, SymSkip, 40); rule(37, 1, SymEof, SymEof, StartState);
      rule(37, 2, SymGt, SymSkip, 22); rule(37, 3, SymWild, SymSkip, 2);
      rule(37, 4, SymWild, SymSkip, 2);
      rule(38, 0, SymHeld, SymSkip, 0); rule(38, 1, SymNl, SymSkip, 39);
      rule(38, 2, SymWild, SymSkip, 0);
      rule(39, 0, SymF, SymSkip, 3);  rule(39, 1, SymEof, SymEof, StartState);
      rule(39, 2, SymGt, SymSkip, 22); rule(39, 3, SymNl, SymSkip, 1);
      rule(39, 4, SymWild, SymSkip, 2);
      reader(40, SymR, SymSkip, 41, SymSkip, 4);
      reader(41, SymO, SymSkip, 42, SymSkip, 7);
      reader(42, SymM, SymSkip, 43, SymSkip, 11);
      reader(43, SymSp, SymSkip, 21, SymSkip, 16);
      parse_state = StartState;
      captured    = '0;
      errors      = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void take_request(logic [7:0] value, logic eof);
      logic [8:0]   input_sym;
      logic [8:0]   first;
      logic [8:0]   sym;
      logic [8:0]   emit_sym;
      logic [5:0]   st;
      int           sel;
      int           first_k;
      int           n;
      mbox_symbol_t s;
      input_sym = eof ? SymEof : {1'b0, value};
      st = (parse_state >= NumStates) ? StartState : parse_state;
      n = 0;
      for (int step = 0; step < 16; step++) begin
        first = rule_match[st][0];
        if (step > 0 && first != SymSkip && first != SymHeld) break;
        sel = 0;
        if (first != SymSkip) begin
          sym     = (first == SymHeld) ? captured : input_sym;
          first_k = (first == SymHeld) ? 1 : 0;
          sel     = first_k;
          for (int k = first_k; k < 5; k++) begin
            if (rule_match[st][k] == SymWild) begin
              captured = sym;
              sel = k;
              break;
            end
            if (rule_match[st][k] == sym) begin
              sel = k;
              break;
            end
          end
        end
        emit_sym = rule_emit[st][sel];
        if (emit_sym == SymWild) emit_sym = captured;
        if (emit_sym != SymSkip && n < 6) begin
          s.value = 8'h00;
          s.last  = 1'b0;
          if (!emit_sym[8]) begin
            s.kind  = KIND_BYTE;
            s.value = emit_sym[7:0];
          end else if (emit_sym == SymMsg) begin
            s.kind = KIND_MSG;
          end else if (emit_sym == SymEmpty) begin
            s.kind = KIND_EMPTY;
          end else begin
            s.kind = KIND_EOF;
          end
          expected_symbols.push_back(s);
          n++;
        end
        st = rule_next[st][sel];
        if (st >= NumStates) st = StartState;
      end
      parse_state = st;
      if (n > 0) expected_symbols[$].last = 1'b1;
    endfunction

    function void check_symbol(kind_t kind, logic [7:0] value, logic last);
      mbox_symbol_t e;
      if (expected_symbols.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected symbol: expected none, got kind %0d byte %02h last %0b",
                   $time, kind, value, last);
        return;
      end
      e = expected_symbols.pop_front();
      kind_count[e.kind]++;
      if (e.kind !== kind || e.value !== value || e.last !== last) begin
        errors++;
        if (errors <= MaxReports)
          $display({"%0t: mismatch: expected kind %0d byte %02h last %0b, ",
                    "got kind %0d byte %02h last %0b"},
                   $time, e.kind, e.value, e.last, kind, value, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  mbox_in_if  in_ch ();
  mbox_out_if out_ch ();

  mbox_message_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  symbol_scoreboard sb;
  mbox_request_t    requests [$];
  int               requests_taken;
  int               cycle_count;
  int               eof_count;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.take_request(in_ch.byte_value, in_ch.end_of_file);
      requests_taken <= requests_taken + 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_symbol(kind_t'(out_ch.symbol_kind), out_ch.out_byte, out_ch.last_of_run);
  end

  function automatic bit calm_window();
    return requests_taken >= 220 && requests_taken < 300;
  endfunction

  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && requests_taken >= 120) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm_window() || $urandom_range(0, 99) >= IdlePercent;
      end
    end
  end

  function automatic void add_byte(logic [7:0] b);
    mbox_request_t r;
    r.value = b;
    r.eof   = 1'b0;
    requests.push_back(r);
  endfunction

  function automatic void add_eof();
    mbox_request_t r;
    r.value = 8'($urandom_range(0, 255));
    r.eof   = 1'b1;
    requests.push_back(r);
  endfunction

  function automatic void add_text(string text);
    for (int i = 0; i < text.len(); i++) add_byte(text[i]);
  endfunction

  function automatic logic [7:0] content_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 8'($urandom_range(0, 255));
    if (pick < 50) return SymF[7:0];
    if (pick < 55) return SymGt[7:0];
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  function automatic void add_random_line();
    string prefix;
    int    pick;
    prefix = "From ";
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      add_eof();
      return;
    end
    if (pick < 12) begin
      repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick >= 35 && pick < 55) begin
      add_text(prefix);
    end else if (pick >= 55 && pick < 70) begin
      repeat ($urandom_range(1, 3)) add_text(">");
      add_text(prefix);
    end else if (pick >= 70) begin
      if ($urandom_range(0, 1)) add_text(">");
      add_text(prefix.substr(0, $urandom_range(0, 3)));
      add_byte(content_byte());
      if ($urandom_range(0, 3) == 0) begin
        add_eof();
        return;
      end
    end
    repeat ($urandom_range(0, 6)) add_byte(content_byte());
    add_text("\n");
  endfunction

  task automatic offer_requests();
    int offered;
    bit must_hold;
    offered = -1;
    while (requests_taken < requests.size()) begin
      @(negedge clk);
      if (requests_taken >= requests.size()) begin
        in_ch.valid <= 1'b0;
        break;
      end
      must_hold = in_ch.valid && offered == requests_taken;
      in_ch.valid       <= must_hold || calm_window() ||
                           $urandom_range(0, 99) >= IdlePercent;
      in_ch.byte_value  <= requests[requests_taken].value;
      in_ch.end_of_file <= requests[requests_taken].eof;
      offered = requests_taken;
    end
  endtask

  initial begin
    int directed_count;
    sb = new();
    cycle_count       = 0;
    requests_taken    = 0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.byte_value  = 8'h00;
    in_ch.end_of_file = 1'b0;

    add_eof();
    add_text("From \n");
    add_byte(8'h00);
    add_byte(8'hff);
    add_text("\n>From ");
    add_text("\nFrom \n");
    add_text(">F");
    add_eof();
    add_eof();
    directed_count = requests.size();
    while (requests.size() < directed_count + RandomCount) add_random_line();
    add_eof();
    eof_count = 0;
    foreach (requests[i]) if (requests[i].eof) eof_count++;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer_requests();
    while (sb.expected_symbols.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    sb.errors += sb.expected_symbols.size();

    $display("Drove %0d requests (%0d end-of-file marks) through random stalls on both sides.",
             requests.size(), eof_count);
    $display("Checked %0d bytes, %0d message boundaries, %0d end-of-file, %0d empty-mailbox.",
             sb.kind_count[KIND_BYTE], sb.kind_count[KIND_MSG],
             sb.kind_count[KIND_EOF], sb.kind_count[KIND_EMPTY]);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
